[rtl/cwpm_pkg.sv]
// Shared types, constants and helpers for the cache way partition manager.
package cwpm_pkg;

	localparam int MAX_CLASSES = 16;
	localparam int MAX_WAYS    = 32;
	localparam int POOL        = MAX_CLASSES - 1;

	localparam logic [5:0] RESET_TOTAL_WAYS = 6'd20;
	localparam logic [4:0] RESET_CLASSES    = 5'd16;

	localparam logic [1:0] REQ_INSERT    = 2'd0;
	localparam logic [1:0] REQ_RM_REFLOW = 2'd1;
	localparam logic [1:0] REQ_RM_KEEP   = 2'd2;
	localparam logic [1:0] REQ_NONE      = 2'd3;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NO_FREE      = 2'd1;
	localparam logic [1:0] ST_NOT_ASSIGNED = 2'd2;

	localparam logic CFG_TOTAL_WAYS  = 1'b0;
	localparam logic CFG_NUM_CLASSES = 1'b1;

	typedef enum logic [1:0] {
		DIV_GAP  = 2'd0,
		DIV_RND  = 2'd1,
		DIV_FAIR = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     pop;
		logic     div_start;
		div_sel_t div_sel;
		logic     scan_init;
		logic     scan_step;
		logic     gap_rnd;
		logic     place;
		logic     rm;
		logic     fair_load;
		logic     refl_step;
		logic     emit_err;
		logic     emit_ack;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       full_err;
		logic       pos_err;
		logic       small_list;
		logic       hint_ok;
		logic       ack_case;
		logic       div_done;
		logic       div_rem_zero;
		logic       scan_last;
		logic       refl_last;
		logic       slot_free;
	} sts_t;

	function automatic logic [3:0] cls_idx(input logic [3:0] c);
		return (c == 4'd0) ? 4'd0 : c - 4'd1;
	endfunction

	function automatic logic [31:0] mask_of(input logic [5:0] cnt, input logic [4:0] low);
		logic [32:0] ones;
		ones = (33'd1 << cnt) - 33'd1;
		return ones[31:0] << low;
	endfunction

endpackage

[rtl/cwpm_div.sv]
// Restoring divider, one quotient bit per cycle.
module cwpm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [3:0]  divisor,
	output logic        done,
	output logic [15:0] quo,
	output logic [3:0]  rem
);
	logic [4:0]  acc_q;
	logic [15:0] quo_q;
	logic [3:0]  dv_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  trial;
	logic        fits;

	assign trial = {acc_q[3:0], quo_q[15]};
	assign fits  = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 5'd0;
			quo_q <= dividend;
			dv_q  <= divisor;
		end else if (busy_q) begin
			acc_q <= fits ? trial - {1'b0, dv_q} : trial;
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = acc_q[3:0];

endmodule

[rtl/cwpm_dp.sv]
// Datapath: partition tables, free stack, gap search, reflow and result register.
module cwpm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cwpm_pkg::cmd_t       cmd,
	output cwpm_pkg::sts_t       sts,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [5:0]           cfg_wdata,
	input  logic [1:0]           req_type,
	input  logic signed [4:0]    gap_hint,
	input  logic [3:0]           remove_position,
	input  logic [15:0]          random_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [3:0]           class_id,
	output logic [31:0]          way_mask,
	output logic [4:0]           low_way,
	output logic [5:0]           way_count,
	output logic [3:0]           list_position,
	output logic                 bonus_way,
	output logic [3:0]           bouncing_ways,
	output logic                 last
);
	import cwpm_pkg::*;

	logic [5:0] total_q;
	logic [3:0] assigned_q, free_cnt_q, rem_ways_q;
	logic [3:0] order_q [POOL];
	logic [3:0] stack_q [POOL];
	logic [4:0] start_q [POOL];
	logic [5:0] width_q [POOL];

	logic [1:0]  type_q;
	logic [4:0]  hint_q;
	logic [3:0]  pos_q, nold_q, c_q, gap_q, j_q, step_q;
	logic [15:0] rnd_q;
	logic [5:0]  prevw_q, fair_q, cursor_q;
	logic signed [7:0] best_q;
	logic        asc_q;
	logic [1:0]  nbr_q;
	logic [3:0]  rcnt_q;
	logic signed [4:0] na_q, nb_q, excl_q;
	logic        out_valid_q;

	// divider
	logic [15:0] dv_dividend, dv_quo;
	logic [3:0]  dv_divisor, dv_rem;
	logic        dv_done;

	always_comb begin
		case (cmd.div_sel)
			DIV_RND: begin
				dv_dividend = rnd_q;
				dv_divisor  = nold_q - 4'd1;
			end
			DIV_FAIR: begin
				dv_dividend = {10'd0, total_q};
				dv_divisor  = assigned_q;
			end
			default: begin
				dv_dividend = {10'd0, total_q};
				dv_divisor  = nold_q;
			end
		endcase
	end

	cwpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quo      (dv_quo),
		.rem      (dv_rem)
	);

	// gap scan
	logic [5:0]        scan_w;
	logic signed [7:0] bias;
	assign scan_w = width_q[cls_idx(order_q[j_q])];
	assign bias   = $signed({2'b00, prevw_q}) + $signed({2'b00, scan_w})
	              - $signed({1'b0, fair_q, 1'b0});

	// reflow step
	logic [3:0]  ri, rc, rci;
	logic        r_nbr, r_rem, r_extra;
	logic [5:0]  r_cnt, r_low;
	assign ri      = asc_q ? step_q : assigned_q - 4'd1 - step_q;
	assign rc      = order_q[ri];
	assign rci     = cls_idx(rc);
	assign r_nbr   = (nbr_q != 2'd0) && ($signed({1'b0, ri}) == na_q
	               || $signed({1'b0, ri}) == nb_q);
	assign r_rem   = !r_nbr && (rcnt_q != 4'd0) && ($signed({1'b0, ri}) != excl_q);
	assign r_extra = r_nbr || r_rem;
	assign r_cnt   = fair_q + {5'd0, r_extra};
	assign r_low   = asc_q ? cursor_q : cursor_q - r_cnt;

	// remove
	logic [3:0] rm_c, rm_ci, ack_ci;
	logic [6:0] rm_mid;
	assign rm_c   = order_q[pos_q];
	assign rm_ci  = cls_idx(rm_c);
	assign rm_mid = {2'b00, width_q[rm_ci][5:1]} + {2'b00, start_q[rm_ci]};
	assign ack_ci = cls_idx(c_q);

	// fair load
	logic       interior;
	logic [1:0] nbr_n;
	always_comb begin
		if (type_q == REQ_INSERT)
			interior = (gap_q != 4'd0) && (gap_q != nold_q);
		else
			interior = (pos_q != 4'd0) && (pos_q != nold_q - 4'd1);
		nbr_n = 2'd0;
		if (interior)
			nbr_n = (dv_rem < 4'd2) ? dv_rem[1:0] : 2'd2;
	end

	logic [5:0] wv;
	logic [4:0] cv;
	always_comb begin
		wv = cfg_wdata;
		if (wv < 6'd2)
			wv = 6'd2;
		else if (wv > 6'(MAX_WAYS))
			wv = 6'(MAX_WAYS);
		cv = cfg_wdata[4:0];
		if (cv < 5'd2)
			cv = 5'd2;
		else if (cv > 5'(MAX_CLASSES))
			cv = 5'(MAX_CLASSES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= RESET_TOTAL_WAYS;
			assigned_q <= 4'd0;
			free_cnt_q <= 4'(RESET_CLASSES - 5'd1);
			rem_ways_q <= 4'd0;
			for (int k = 0; k < POOL; k++) begin
				stack_q[k] <= 4'(k + 1);
				start_q[k] <= 5'd0;
				width_q[k] <= RESET_TOTAL_WAYS;
			end
		end else begin
			if (cfg_wr_en && cfg_index == CFG_TOTAL_WAYS)
				total_q <= wv;
			if (cfg_wr_en && cfg_index == CFG_NUM_CLASSES) begin
				assigned_q <= 4'd0;
				free_cnt_q <= 4'(cv - 5'd1);
				rem_ways_q <= 4'd0;
				for (int k = 0; k < POOL; k++) begin
					stack_q[k] <= 4'(k + 1);
					start_q[k] <= 5'd0;
					width_q[k] <= total_q;
				end
			end
			if (cmd.pop) begin
				for (int k = 0; k < POOL - 1; k++)
					stack_q[k] <= stack_q[k + 1];
				free_cnt_q <= free_cnt_q - 4'd1;
			end
			if (cmd.place)
				assigned_q <= assigned_q + 4'd1;
			if (cmd.rm) begin
				for (int k = 1; k < POOL; k++)
					stack_q[k] <= stack_q[k - 1];
				stack_q[0] <= rm_c;
				free_cnt_q <= free_cnt_q + 4'd1;
				assigned_q <= assigned_q - 4'd1;
			end
			if (cmd.fair_load)
				rem_ways_q <= dv_rem;
			if (cmd.emit_ack && type_q == REQ_RM_REFLOW)
				rem_ways_q <= 4'd0;
			if (cmd.refl_step) begin
				start_q[rci] <= r_low[4:0];
				width_q[rci] <= r_cnt;
			end
		end
	end

	// list order and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			hint_q <= gap_hint;
			pos_q  <= remove_position;
			rnd_q  <= random_word;
			nold_q <= assigned_q;
		end
		if (cmd.pop) begin
			c_q <= stack_q[0];
			if (sts.small_list)
				gap_q <= 4'd0;
			else if (sts.hint_ok)
				gap_q <= hint_q[3:0];
		end
		if (cmd.scan_init) begin
			fair_q <= dv_quo[5:0];
			j_q    <= 4'd0;
			best_q <= -8'sd1;
			gap_q  <= 4'd1;
		end
		if (cmd.scan_step) begin
			if (j_q != 4'd0 && bias > best_q) begin
				best_q <= bias;
				gap_q  <= j_q;
			end
			prevw_q <= scan_w;
			j_q     <= j_q + 4'd1;
		end
		if (cmd.gap_rnd)
			gap_q <= dv_rem + 4'd1;
		if (cmd.place) begin
			if (gap_q == 4'd0)
				order_q[0] <= c_q;
			for (int k = 1; k < POOL; k++) begin
				if (4'(k) == gap_q)
					order_q[k] <= c_q;
				else if (4'(k) > gap_q)
					order_q[k] <= order_q[k - 1];
			end
		end
		if (cmd.rm) begin
			c_q   <= rm_c;
			asc_q <= rm_mid <= {2'b00, total_q[5:1]};
			for (int k = 0; k < POOL - 1; k++) begin
				if (4'(k) >= pos_q)
					order_q[k] <= order_q[k + 1];
			end
		end
		if (cmd.fair_load) begin
			fair_q <= dv_quo[5:0];
			nbr_q  <= nbr_n;
			rcnt_q <= dv_rem - {2'b00, nbr_n};
			step_q <= 4'd0;
			if (type_q == REQ_INSERT) begin
				asc_q    <= gap_q <= {1'b0, nold_q[3:1]};
				cursor_q <= (gap_q <= {1'b0, nold_q[3:1]}) ? 6'd0 : total_q;
				na_q     <= $signed({1'b0, gap_q}) + 5'sd1;
				nb_q     <= $signed({1'b0, gap_q}) - 5'sd1;
				excl_q   <= $signed({1'b0, gap_q});
			end else begin
				cursor_q <= asc_q ? 6'd0 : total_q;
				na_q     <= $signed({1'b0, pos_q});
				nb_q     <= $signed({1'b0, pos_q}) - 5'sd1;
				excl_q   <= -5'sd1;
			end
		end
		if (cmd.refl_step) begin
			step_q   <= step_q + 4'd1;
			cursor_q <= asc_q ? cursor_q + r_cnt : r_low;
			if (r_nbr)
				nbr_q <= nbr_q - 2'd1;
			if (r_rem)
				rcnt_q <= rcnt_q - 4'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_err || cmd.emit_ack || cmd.refl_step)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			status        <= (type_q == REQ_INSERT) ? ST_NO_FREE : ST_NOT_ASSIGNED;
			class_id      <= 4'd0;
			way_mask      <= 32'd0;
			low_way       <= 5'd0;
			way_count     <= 6'd0;
			list_position <= 4'd0;
			bonus_way     <= 1'b0;
			bouncing_ways <= 4'd0;
			last          <= 1'b1;
		end else if (cmd.emit_ack) begin
			status        <= ST_OK;
			class_id      <= c_q;
			way_mask      <= mask_of(width_q[ack_ci], start_q[ack_ci]);
			low_way       <= start_q[ack_ci];
			way_count     <= width_q[ack_ci];
			list_position <= pos_q;
			bonus_way     <= 1'b0;
			bouncing_ways <= (type_q == REQ_RM_REFLOW) ? 4'd0 : rem_ways_q;
			last          <= 1'b1;
		end else if (cmd.refl_step) begin
			status        <= ST_OK;
			class_id      <= rc;
			way_mask      <= mask_of(r_cnt, r_low[4:0]);
			low_way       <= r_low[4:0];
			way_count     <= r_cnt;
			list_position <= ri;
			bonus_way     <= r_extra;
			bouncing_ways <= rem_ways_q;
			last          <= sts.refl_last;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.req_type     = type_q;
		sts.full_err     = (free_cnt_q == 4'd0) || (assigned_q == 4'(POOL));
		sts.pos_err      = pos_q >= assigned_q;
		sts.small_list   = nold_q < 4'd2;
		sts.hint_ok      = !hint_q[4] && (hint_q[3:0] <= nold_q);
		sts.ack_case     = (type_q == REQ_RM_KEEP) || (nold_q == 4'd1);
		sts.div_done     = dv_done;
		sts.div_rem_zero = dv_rem == 4'd0;
		sts.scan_last    = j_q == nold_q - 4'd1;
		sts.refl_last    = step_q == assigned_q - 4'd1;
		sts.slot_free    = !out_valid_q || !out_stall;
	end

	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, assigned_q} + {1'b0, free_cnt_q}) <= 5'(POOL))
		else $error("assigned plus free classes exceed pool");
	a_err_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status != ST_OK |-> way_mask == 32'd0 && last)
		else $error("error result carries payload");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && !cfg_wr_en |=> free_cnt_q == $past(free_cnt_q) - 4'd1)
		else $error("free count not decremented on pop");

endmodule

[rtl/cwpm_ctrl.sv]
// Controller: sequences decode, gap choice, list update, division and reflow.
module cwpm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cwpm_pkg::sts_t sts,
	output cwpm_pkg::cmd_t cmd
);
	import cwpm_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DEC    = 13'b0000000000010,
		S_ERR    = 13'b0000000000100,
		S_POP    = 13'b0000000001000,
		S_GDIV   = 13'b0000000010000,
		S_RDIV   = 13'b0000000100000,
		S_SCAN   = 13'b0000001000000,
		S_PLACE  = 13'b0000010000000,
		S_FSTART = 13'b0000100000000,
		S_FDIV   = 13'b0001000000000,
		S_RM     = 13'b0010000000000,
		S_ACK    = 13'b0100000000000,
		S_REFL   = 13'b1000000000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_GAP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.req_type == REQ_NONE)
					state_n = S_IDLE;
				else if (sts.req_type == REQ_INSERT)
					state_n = sts.full_err ? S_ERR : S_POP;
				else
					state_n = sts.pos_err ? S_ERR : S_RM;
			end
			S_ERR: begin
				if (sts.slot_free) begin
					cmd.emit_err = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				if (sts.small_list || sts.hint_ok) begin
					state_n = S_PLACE;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_GDIV;
				end
			end
			S_GDIV: begin
				if (sts.div_done) begin
					if (sts.div_rem_zero) begin
						// even split: random gap
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_RND;
						state_n       = S_RDIV;
					end else begin
						cmd.scan_init = 1'b1;
						state_n       = S_SCAN;
					end
				end
			end
			S_RDIV: begin
				cmd.div_sel = DIV_RND;
				if (sts.div_done) begin
					cmd.gap_rnd = 1'b1;
					state_n     = S_PLACE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_n = S_PLACE;
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_n   = S_FSTART;
			end
			S_FSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_FAIR;
				state_n       = S_FDIV;
			end
			S_FDIV: begin
				cmd.div_sel = DIV_FAIR;
				if (sts.div_done) begin
					cmd.fair_load = 1'b1;
					state_n       = S_REFL;
				end
			end
			S_RM: begin
				cmd.rm  = 1'b1;
				state_n = sts.ack_case ? S_ACK : S_FSTART;
			end
			S_ACK: begin
				if (sts.slot_free) begin
					cmd.emit_ack = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_REFL: begin
				if (sts.slot_free) begin
					cmd.refl_step = 1'b1;
					if (sts.refl_last)
						state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	assign in_stall = state_q != S_IDLE;

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_err, cmd.emit_ack, cmd.refl_step}))
		else $error("two results issued in one cycle");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_err || cmd.emit_ack || cmd.refl_step) |-> sts.slot_free)
		else $error("result issued into occupied output register");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DEC)
		else $error("request load did not move to decode");

endmodule

[rtl/cache_way_partition_manager.sv]
// Top level of the cache way partition manager.
//   channel  | handshake               | payload
//   request  | in_valid / in_stall     | req_type gap_hint remove_position random_word
//   result   | out_valid / out_stall   | status class_id way_mask low_way way_count
//            |                         | list_position bonus_way bouncing_ways last
//   config   | cfg_wr_en               | cfg_index cfg_wdata
// One request at a time. Insert: one division for the fair share plus none, one
// or two for the gap choice, a gap-scan step per list entry, then one result per
// reflow step; remove: one division before the reflow, none for a keep request
// or the last class. Reset clears all control state. A stalled output holds the
// next reflow step; in_stall stays high until the last result of the request is
// in the output register.
module cache_way_partition_manager (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [5:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic signed [4:0] gap_hint,
	input  logic [3:0]        remove_position,
	input  logic [15:0]       random_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [3:0]        class_id,
	output logic [31:0]       way_mask,
	output logic [4:0]        low_way,
	output logic [5:0]        way_count,
	output logic [3:0]        list_position,
	output logic              bonus_way,
	output logic [3:0]        bouncing_ways,
	output logic              last
);
	import cwpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cwpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cwpm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req_type),
		.gap_hint        (gap_hint),
		.remove_position (remove_position),
		.random_word     (random_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.class_id        (class_id),
		.way_mask        (way_mask),
		.low_way         (low_way),
		.way_count       (way_count),
		.list_position   (list_position),
		.bonus_way       (bonus_way),
		.bouncing_ways   (bouncing_ways),
		.last            (last)
	);

endmodule

[sim/cwpm_checker.sv]
// Result checker for the cache way partition manager: tracks partition state and compares outputs.
`timescale 1ns / 1ps
module cwpm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [5:0]        cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic signed [4:0] gap_hint,
	input  logic [3:0]        remove_position,
	input  logic [15:0]       random_word,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [3:0]        class_id,
	input  logic [31:0]       way_mask,
	input  logic [4:0]        low_way,
	input  logic [5:0]        way_count,
	input  logic [3:0]        list_position,
	input  logic              bonus_way,
	input  logic [3:0]        bouncing_ways,
	input  logic              last,
	output int                pending,
	output int                fail_count
);
	import cwpm_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  class_id;
		logic [31:0] way_mask;
		logic [4:0]  low_way;
		logic [5:0]  way_count;
		logic [3:0]  list_position;
		logic        bonus_way;
		logic [3:0]  bouncing_ways;
		logic        last;
	} part_result_t;

	part_result_t part_q[$];

	logic [3:0] order_list[POOL];
	logic [3:0] free_stk[POOL];
	logic [4:0] start_way[POOL];
	logic [5:0] width_ways[POOL];
	int tot_ways, n_classes, n_assigned, n_free, rem_ways;

	function automatic int cidx(logic [3:0] c);
		return (c >= 1) ? int'(c) - 1 : 0;
	endfunction

	task automatic rebuild_parts();
		n_assigned = 0;
		n_free = n_classes - 1;
		rem_ways = 0;
		for (int i = 0; i < POOL; i++) begin
			order_list[i] = '0;
			free_stk[i] = 4'(i + 1);
			start_way[i] = '0;
			width_ways[i] = 6'(tot_ways);
		end
	endtask

	task automatic add_result(logic [1:0] st, logic [3:0] cls, int low, int cnt, int pos,
			int extra, int bounce, int lst);
		part_result_t r;
		logic [63:0] m;
		low = low & 31;
		if (cnt > 32) cnt = 32;
		m = '0;
		if (st == ST_OK) m = ((64'd1 << cnt) - 64'd1) << low;
		r.status = st;
		r.class_id = cls;
		r.way_mask = m[31:0];
		r.low_way = 5'(low);
		r.way_count = 6'(cnt);
		r.list_position = 4'(pos);
		r.bonus_way = 1'(extra);
		r.bouncing_ways = 4'(bounce);
		r.last = 1'(lst);
		part_q.push_back(r);
	endtask

	task automatic reflow_ways(int n, bit asc, int fair, int nbr, int rem, int na, int nb,
			int excl);
		int cursor, i, extra, cnt, low;
		cursor = asc ? 0 : tot_ways;
		for (int s = 0; s < n; s++) begin
			i = asc ? s : n - 1 - s;
			extra = 0;
			if (nbr > 0 && (i == na || i == nb)) begin
				extra = 1;
				nbr--;
			end else if (rem > 0 && i != excl) begin
				extra = 1;
				rem--;
			end
			cnt = fair + extra;
			if (asc) begin
				low = cursor;
				cursor += cnt;
			end else begin
				cursor -= cnt;
				low = cursor;
			end
			start_way[cidx(order_list[i])] = 5'(low);
			width_ways[cidx(order_list[i])] = 6'(cnt);
			add_result(ST_OK, order_list[i], low, cnt, i, extra, rem_ways, s == n - 1);
		end
	endtask

	task automatic predict_insert(int hint, logic [15:0] rnd);
		int n_old, gap, fair, rem, nbr, best, b;
		logic [3:0] c;
		n_old = n_assigned;
		nbr = 0;
		if (n_free == 0 || n_assigned >= POOL) begin
			add_result(ST_NO_FREE, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		c = free_stk[0];
		for (int k = 0; k < POOL - 1; k++) free_stk[k] = free_stk[k + 1];
		n_free--;
		if (n_old < 2) begin
			gap = 0;
		end else if (hint < 0 || hint > n_old) begin
			fair = tot_ways / n_old;
			if (tot_ways % n_old == 0) begin
				gap = int'(rnd) % (n_old - 1) + 1;
			end else begin
				// no qualifying bias falls back to gap 1
				gap = 1;
				best = -1;
				for (int i = 1; i < n_old; i++) begin
					b = int'(width_ways[cidx(order_list[i - 1])]) +
						int'(width_ways[cidx(order_list[i])]) - 2 * fair;
					if (b > best) begin
						best = b;
						gap = i;
					end
				end
			end
		end else begin
			gap = hint;
		end
		for (int k = n_old; k > gap; k--) order_list[k] = order_list[k - 1];
		order_list[gap] = c;
		n_assigned++;
		fair = tot_ways / (n_old + 1);
		rem = tot_ways % (n_old + 1);
		rem_ways = rem;
		if (gap != 0 && gap != n_old) begin
			nbr = rem < 2 ? rem : 2;
			rem -= nbr;
		end
		reflow_ways(n_old + 1, gap <= (n_old >> 1), fair, nbr, rem, gap + 1, gap - 1, gap);
	endtask

	task automatic predict_remove(int p, bit resize);
		int n_old, ci, fair, rem, nbr, n;
		bit asc;
		logic [3:0] c;
		n_old = n_assigned;
		nbr = 0;
		if (p >= n_assigned) begin
			add_result(ST_NOT_ASSIGNED, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		c = order_list[p];
		ci = cidx(c);
		asc = (int'(width_ways[ci] >> 1) + int'(start_way[ci])) <= (tot_ways >> 1);
		for (int k = p; k < n_old - 1; k++) order_list[k] = order_list[k + 1];
		n_assigned--;
		for (int k = POOL - 1; k > 0; k--) free_stk[k] = free_stk[k - 1];
		free_stk[0] = c;
		n_free++;
		n = n_old - 1;
		if (!resize || n == 0) begin
			if (resize) rem_ways = 0;
			add_result(ST_OK, c, start_way[ci], width_ways[ci], p, 0, rem_ways, 1);
			return;
		end
		fair = tot_ways / n;
		rem = tot_ways % n;
		rem_ways = rem;
		if (p != 0 && p != n_old - 1) begin
			nbr = rem < 2 ? rem : 2;
			rem -= nbr;
		end
		reflow_ways(n, asc, fair, nbr, rem, p, p - 1, -1);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q.delete();
			pending = 0;
			fail_count = 0;
			tot_ways = RESET_TOTAL_WAYS;
			n_classes = RESET_CLASSES;
			rebuild_parts();
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_TOTAL_WAYS) begin
					tot_ways = int'(cfg_wdata);
					if (tot_ways < 2) tot_ways = 2;
					if (tot_ways > MAX_WAYS) tot_ways = MAX_WAYS;
				end else begin
					n_classes = int'(cfg_wdata[4:0]);
					if (n_classes < 2) n_classes = 2;
					if (n_classes > MAX_CLASSES) n_classes = MAX_CLASSES;
					rebuild_parts();
				end
			end
			if (out_valid && !out_stall) begin
				if (part_q.size() == 0) begin
					$error("unexpected result: class_id %0h", class_id);
					fail_count++;
				end else begin
					part_result_t e;
					e = part_q.pop_front();
					check_field("status", e.status, status);
					check_field("class_id", e.class_id, class_id);
					check_field("way_mask", e.way_mask, way_mask);
					check_field("low_way", e.low_way, low_way);
					check_field("way_count", e.way_count, way_count);
					check_field("list_position", e.list_position, list_position);
					check_field("bonus_way", e.bonus_way, bonus_way);
					check_field("bouncing_ways", e.bouncing_ways, bouncing_ways);
					check_field("last", e.last, last);
				end
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					REQ_INSERT:    predict_insert(int'(gap_hint), random_word);
					REQ_RM_REFLOW: predict_remove(int'(remove_position), 1'b1);
					REQ_RM_KEEP:   predict_remove(int'(remove_position), 1'b0);
					default: ;
				endcase
			end
			pending = part_q.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top: drives requests and register writes, and reports the verdict.
`timescale 1ns / 1ps
module tb;
	import cwpm_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic              cfg_index;
	logic [5:0]        cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        req_type;
	logic signed [4:0] gap_hint;
	logic [3:0]        remove_position;
	logic [15:0]       random_word;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [3:0]        class_id;
	logic [31:0]       way_mask;
	logic [4:0]        low_way;
	logic [5:0]        way_count;
	logic [3:0]        list_position;
	logic              bonus_way;
	logic [3:0]        bouncing_ways;
	logic              last;
	int                pending;
	int                fail_count;
	int                send_idle_pct;
	int                stall_pct;

	cache_way_partition_manager u_top (.*);

	cwpm_checker u_chk (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	task automatic send_req(logic [1:0] t, logic [4:0] h, logic [3:0] p, logic [15:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		gap_hint <= h;
		remove_position <= p;
		random_word <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [5:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// requests with no result may still be in flight
		repeat (300) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_req();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			send_req(REQ_INSERT, 5'($urandom_range(31)), 4'($urandom_range(15)), 16'($urandom));
		else if (sel < 72)
			send_req(REQ_RM_REFLOW, 5'($urandom_range(31)),
				4'($urandom_range(99) < 85 ? $urandom_range(7) : $urandom_range(15)),
				16'($urandom));
		else if (sel < 94)
			send_req(REQ_RM_KEEP, 5'($urandom_range(31)),
				4'($urandom_range(99) < 85 ? $urandom_range(7) : $urandom_range(15)),
				16'($urandom));
		else
			send_req(REQ_NONE, 5'($urandom_range(31)), 4'($urandom_range(15)), 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_TOTAL_WAYS;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		gap_hint = '0;
		remove_position = '0;
		random_word = '0;
		out_stall = 1'b0;
		send_idle_pct = 7;
		stall_pct = 74;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list errors, auto and explicit gaps, fill to full
		send_req(REQ_RM_REFLOW, 5'd0, 4'd0, 16'h0000);
		send_req(REQ_RM_KEEP, 5'd0, 4'd14, 16'hffff);
		send_req(REQ_INSERT, 5'h1f, 4'd0, 16'h0000);
		send_req(REQ_RM_REFLOW, 5'd0, 4'd0, 16'h0000);
		send_req(REQ_INSERT, 5'd0, 4'd0, 16'h0000);
		send_req(REQ_INSERT, 5'd15, 4'd0, 16'hffff);
		send_req(REQ_INSERT, 5'h10, 4'd0, 16'h1234);
		send_req(REQ_INSERT, 5'd2, 4'd0, 16'h0001);
		send_req(REQ_NONE, 5'h0f, 4'd15, 16'hffff);
		send_req(REQ_INSERT, 5'h1f, 4'd0, 16'hfffe);
		for (int i = 0; i < 11; i++) send_req(REQ_INSERT, 5'($urandom_range(31)), 4'd0,
			16'($urandom));
		send_req(REQ_RM_REFLOW, 5'd0, 4'd14, 16'h0000);
		send_req(REQ_RM_KEEP, 5'd0, 4'd15, 16'h0000);
		send_req(REQ_RM_REFLOW, 5'd0, 4'd0, 16'h0000);
		send_req(REQ_RM_KEEP, 5'd0, 4'd6, 16'h0000);

		// extreme settings, including clamped writes
		write_reg(CFG_TOTAL_WAYS, 6'd63);
		write_reg(CFG_NUM_CLASSES, 6'd2);
		send_req(REQ_INSERT, 5'h1f, 4'd0, 16'h0);
		send_req(REQ_INSERT, 5'h1f, 4'd0, 16'h0);
		write_reg(CFG_TOTAL_WAYS, 6'd0);
		write_reg(CFG_NUM_CLASSES, 6'd31);

		for (int i = 0; i < 105; i++) begin
			if (i == 35) begin
				send_idle_pct = 74;
				stall_pct = 7;
			end else if (i == 70) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			if (i % 22 == 21) begin
				write_reg(CFG_TOTAL_WAYS, ($urandom_range(3) == 0) ?
					6'($urandom_range(63)) : 6'($urandom_range(32, 2)));
				if ($urandom_range(1)) write_reg(CFG_NUM_CLASSES, 6'($urandom_range(63)));
			end
			random_req();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
